FILE: rtl/core/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg: shared types and constants of the stepper valve positioner
// Transaction payloads, request and register codes, and coil tables.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int POSITION_BITS = 15;
    localparam int JOG_BITS      = 15;
    localparam int TICK_BITS     = 8;
    localparam int COIL_BITS     = 4;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [POSITION_BITS-1:0] MAX_POSITION_RESET = POSITION_BITS'(512);
    localparam logic [TICK_BITS-1:0]     STEP_TICKS_RESET   = TICK_BITS'(1);

    // Request codes.
    localparam logic [2:0] REQ_MOVE       = 3'd0;
    localparam logic [2:0] REQ_JOG_OPEN   = 3'd1;
    localparam logic [2:0] REQ_JOG_CLOSE  = 3'd2;
    localparam logic [2:0] REQ_TICK       = 3'd3;
    localparam logic [2:0] REQ_STATUS     = 3'd4;

    // Valve state codes.
    localparam logic [1:0] VS_CLOSED  = 2'd0;
    localparam logic [1:0] VS_OPEN    = 2'd1;
    localparam logic [1:0] VS_TRANSIT = 2'd2;

    // Register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_MIN_POSITION = 2'd0;
    localparam logic [1:0] REG_MAX_POSITION = 2'd1;
    localparam logic [1:0] REG_STEP_TICKS   = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_MOVE,
        MODE_JOG_OPEN,
        MODE_JOG_CLOSE
    } t_run_mode;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] target_position;
        logic signed [15:0] jog_steps;
    } t_in_item;

    typedef struct packed {
        logic [COIL_BITS-1:0]     coil_pattern;
        logic [POSITION_BITS-1:0] position;
        logic [1:0]               valve_state;
        logic                     busy_res;
        logic                     step_taken;
        logic                     move_done;
        logic                     accepted;
    } t_out_item;

    typedef struct packed {
        logic [POSITION_BITS-1:0] min_position;
        logic [POSITION_BITS-1:0] max_position;
        logic [TICK_BITS-1:0]     step_ticks;
    } t_cfg;

    // Full-step two-coil sequence, opening direction.
    function automatic logic [COIL_BITS-1:0] fwd_pattern(input logic [1:0] idx);
        logic [COIL_BITS-1:0] pat;
        unique case (idx)
            2'd0: pat = 4'h9;
            2'd1: pat = 4'hA;
            2'd2: pat = 4'h6;
            2'd3: pat = 4'h5;
        endcase
        return pat;
    endfunction

    // The same sequence walked backwards, closing direction.
    function automatic logic [COIL_BITS-1:0] rev_pattern(input logic [1:0] idx);
        logic [COIL_BITS-1:0] pat;
        unique case (idx)
            2'd0: pat = 4'h5;
            2'd1: pat = 4'h6;
            2'd2: pat = 4'hA;
            2'd3: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

FILE: rtl/core/svp_cfg_regs.sv
// ----------------------------------------------------------------------------
// svp_cfg_regs: configuration register file
// Holds the position limits and the step period behind an APB-style port.
// ----------------------------------------------------------------------------
module svp_cfg_regs
    import svp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    logic [POSITION_BITS-1:0] r_min_position;
    logic [POSITION_BITS-1:0] r_max_position;
    logic [TICK_BITS-1:0]     r_step_ticks;
    logic                     wr_en;
    logic [1:0]               reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_position <= '0;
            r_max_position <= MAX_POSITION_RESET;
            r_step_ticks   <= STEP_TICKS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_POSITION: r_min_position <= pwdata[POSITION_BITS-1:0];
                REG_MAX_POSITION: r_max_position <= pwdata[POSITION_BITS-1:0];
                REG_STEP_TICKS:   r_step_ticks   <= pwdata[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_POSITION: prdata = APB_DATA_BITS'(r_min_position);
            REG_MAX_POSITION: prdata = APB_DATA_BITS'(r_max_position);
            REG_STEP_TICKS:   prdata = APB_DATA_BITS'(r_step_ticks);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.min_position = r_min_position;
    assign o_cfg.max_position = r_max_position;
    assign o_cfg.step_ticks   = r_step_ticks;

endmodule

FILE: rtl/core/svp_seq_core.sv
// ----------------------------------------------------------------------------
// svp_seq_core: stepper sequencer state and next-state logic
// Decodes one request, advances the move or jog and forms its result.
// ----------------------------------------------------------------------------
module svp_seq_core
    import svp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [POSITION_BITS-1:0] r_target, n_target;
    t_run_mode                r_mode,   n_mode;
    logic [JOG_BITS-1:0]      r_rem,    n_rem;
    logic [1:0]               r_phase,  n_phase;
    logic [TICK_BITS-1:0]     r_tick,   n_tick;
    logic [COIL_BITS-1:0]     r_coil,   n_coil;

    logic                     busy;
    logic                     accepted;
    logic                     do_step;
    logic                     stepped;
    logic                     done;
    logic [TICK_BITS-1:0]     period;
    logic [TICK_BITS-1:0]     tick_inc;
    logic                     jog_valid;
    logic signed [15:0]       max_s;
    logic signed [15:0]       min_s;
    logic signed [15:0]       clamp_hi;
    logic signed [15:0]       clamp_lo;
    logic [POSITION_BITS-1:0] clamped;
    logic [1:0]               valve_state;

    assign busy      = (r_mode != MODE_IDLE);
    assign period    = (i_cfg.step_ticks == '0) ? TICK_BITS'(1) : i_cfg.step_ticks;
    assign tick_inc  = r_tick + TICK_BITS'(1);
    assign jog_valid = !i_item.jog_steps[15] && (i_item.jog_steps != '0);

    // Clamp to the upper limit first, then raise to the lower; the lower limit
    // wins when the limits are inverted.
    assign max_s    = $signed({1'b0, i_cfg.max_position});
    assign min_s    = $signed({1'b0, i_cfg.min_position});
    assign clamp_hi = (i_item.target_position > max_s) ? max_s : i_item.target_position;
    assign clamp_lo = (clamp_hi < min_s) ? min_s : clamp_hi;
    assign clamped  = clamp_lo[POSITION_BITS-1:0];

    always_comb begin
        n_pos    = r_pos;
        n_target = r_target;
        n_mode   = r_mode;
        n_rem    = r_rem;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_coil   = r_coil;
        accepted = 1'b1;
        do_step  = 1'b0;
        stepped  = 1'b0;
        done     = 1'b0;

        unique case (i_item.req_type)
            REQ_MOVE: begin
                if (busy) begin
                    accepted = 1'b0;
                end else if (clamped != r_pos) begin
                    n_target = clamped;
                    n_mode   = MODE_MOVE;
                    n_tick   = '0;
                    do_step  = 1'b1;
                end
            end
            REQ_JOG_OPEN, REQ_JOG_CLOSE: begin
                if (busy) begin
                    accepted = 1'b0;
                end else if (jog_valid) begin
                    n_rem   = i_item.jog_steps[JOG_BITS-1:0];
                    n_phase = '0;
                    n_mode  = (i_item.req_type == REQ_JOG_OPEN) ? MODE_JOG_OPEN
                                                                : MODE_JOG_CLOSE;
                    n_tick  = '0;
                    do_step = 1'b1;
                end
            end
            REQ_TICK: begin
                if (busy) begin
                    if (tick_inc >= period) begin
                        n_tick  = '0;
                        do_step = 1'b1;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
            end
            REQ_STATUS: ;
            default: accepted = 1'b0;
        endcase

        // One step time, applied to the state as set up above.
        if (do_step) begin
            unique case (n_mode)
                MODE_MOVE: begin
                    if (r_pos == n_target) begin
                        n_coil = '0;
                        n_mode = MODE_IDLE;
                        done   = 1'b1;
                    end else if (n_target > r_pos) begin
                        n_coil  = fwd_pattern(r_pos[1:0]);
                        n_pos   = r_pos + POSITION_BITS'(1);
                        stepped = 1'b1;
                    end else begin
                        n_coil  = rev_pattern(r_pos[1:0] - 2'd1);
                        n_pos   = r_pos - POSITION_BITS'(1);
                        stepped = 1'b1;
                    end
                end
                MODE_JOG_OPEN, MODE_JOG_CLOSE: begin
                    if (n_rem == '0) begin
                        n_mode = MODE_IDLE;
                        done   = 1'b1;
                    end else begin
                        n_coil  = (n_mode == MODE_JOG_OPEN) ? fwd_pattern(n_phase)
                                                            : rev_pattern(n_phase);
                        n_phase = n_phase + 2'd1;
                        n_rem   = n_rem - JOG_BITS'(1);
                        stepped = 1'b1;
                    end
                end
                MODE_IDLE: ;
            endcase
        end
    end

    always_comb begin
        priority if (n_pos == i_cfg.min_position) begin
            valve_state = VS_CLOSED;
        end else if (n_pos == i_cfg.max_position) begin
            valve_state = VS_OPEN;
        end else begin
            valve_state = VS_TRANSIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_target <= '0;
            r_mode   <= MODE_IDLE;
            r_rem    <= '0;
            r_phase  <= '0;
            r_tick   <= '0;
            r_coil   <= '0;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_target <= n_target;
            r_mode   <= n_mode;
            r_rem    <= n_rem;
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_coil   <= n_coil;
        end
    end

    assign o_res.coil_pattern = n_coil;
    assign o_res.position     = n_pos;
    assign o_res.valve_state  = valve_state;
    assign o_res.busy_res     = (n_mode != MODE_IDLE);
    assign o_res.step_taken   = stepped;
    assign o_res.move_done    = done;
    assign o_res.accepted     = accepted;

endmodule

FILE: rtl/core/stepper_valve_positioner.sv
// ----------------------------------------------------------------------------
// stepper_valve_positioner: four-coil stepper valve sequencer
// Request and result channels around a single-pass sequencer core.
// ----------------------------------------------------------------------------
// Every request (move, jog, tick or status query) gives exactly one result
// transaction. The block takes one request per clock cycle while o_in_stall is low.
// A request waits in the input register; when it advances, the sequencer state
// and the result register are updated together, and its result is offered.
// The result register frees as it is read, so a stalled result only holds back
// the input once the input register is full. The user must write limits and the
// step period through the APB port only while no request is outstanding; the
// block itself does not enforce this. pready is always high.
module stepper_valve_positioner
    import svp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item core_res;
    logic      out_free;
    logic      advance;
    logic      in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    svp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    svp_seq_core u_seq_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_res     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A finished move or jog leaves the block idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.move_done |-> !o_out_data.busy_res)
        else $error("move_done reported while still busy");

    // A step and the end of an operation never fall on the same transaction.
    a_step_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.step_taken && o_out_data.move_done))
        else $error("step_taken and move_done both set");

    // A rejected request must not move the coils.
    a_reject_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.accepted |-> !o_out_data.step_taken)
        else $error("step taken on a rejected request");

    // The input is held back only when both stages are full and the output stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a full pipeline");

endmodule
